// ----- src/jsr2d_pkg.sv -----
package jsr2d_pkg;

    localparam int GRAD_W     = 32;
    localparam int STRESS_W   = 32;
    localparam int TEMP_W     = 16;
    localparam int SUM_W      = 48;
    localparam int MOD_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SHEAR_DEFAULT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_KNOT_A   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_KNOT_B   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_KNOT_C   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_KNOT_A    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_KNOT_B    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_KNOT_C    = 3'd7;

    typedef struct packed {
        logic [MOD_W-1:0]  shear_default;
        logic              table_en;
        logic [TEMP_W-1:0] temp_a;
        logic [TEMP_W-1:0] temp_b;
        logic [TEMP_W-1:0] temp_c;
        logic [MOD_W-1:0]  mod_a;
        logic [MOD_W-1:0]  mod_b;
        logic [MOD_W-1:0]  mod_c;
    } cfg_t;

endpackage

// ----- src/jaumann_stress_rate_2d_unit.sv -----
// Jaumann hypoelastic stress-rate accumulator, planar form. One particle enters per clock
// while s_ready is high; each transfer on the s_ channel yields exactly one transfer on the
// m_ channel, in order. The unit adds 2G(a - tr/3) - 2w*sxy, 2G(b - tr/3) + 2w*sxy,
// G(vx_y + vy_x) + w(sxx - syy) and -2G*tr/3 to the four incoming sums (Q32.16), each rate
// rounded once toward minus infinity, and saturates the sums to 48 bits; m_saturated flags
// any clamp. G is the default shear modulus or, with table_enable set, a three-knot
// interpolation over temperature. Sustained rate is one item per cycle while the skid entry
// is empty; an s_ transfer reaches m_valid through the 13-stage datapath (modulus lookup
// with a 4-stage 8-bit-per-stage divider, multipliers up to 34x32, a 2-stage divide by
// three, saturation) and the output register. A skid entry behind the output register keeps
// s_ready high while one result waits on m_ready. Configuration writes take effect at once
// and are expected only while the unit is empty.
module jaumann_stress_rate_2d_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [jsr2d_pkg::GRAD_W-1:0]    s_grad_vx_x,
    input  logic signed [jsr2d_pkg::GRAD_W-1:0]    s_grad_vx_y,
    input  logic signed [jsr2d_pkg::GRAD_W-1:0]    s_grad_vy_x,
    input  logic signed [jsr2d_pkg::GRAD_W-1:0]    s_grad_vy_y,
    input  logic signed [jsr2d_pkg::STRESS_W-1:0]  s_stress_xx,
    input  logic signed [jsr2d_pkg::STRESS_W-1:0]  s_stress_xy,
    input  logic signed [jsr2d_pkg::STRESS_W-1:0]  s_stress_yy,
    input  logic        [jsr2d_pkg::TEMP_W-1:0]    s_temperature,
    input  logic signed [jsr2d_pkg::SUM_W-1:0]     s_rate_sum_xx_in,
    input  logic signed [jsr2d_pkg::SUM_W-1:0]     s_rate_sum_xy_in,
    input  logic signed [jsr2d_pkg::SUM_W-1:0]     s_rate_sum_yy_in,
    input  logic signed [jsr2d_pkg::SUM_W-1:0]     s_rate_sum_zz_in,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [jsr2d_pkg::SUM_W-1:0]     m_rate_sum_xx_out,
    output logic signed [jsr2d_pkg::SUM_W-1:0]     m_rate_sum_xy_out,
    output logic signed [jsr2d_pkg::SUM_W-1:0]     m_rate_sum_yy_out,
    output logic signed [jsr2d_pkg::SUM_W-1:0]     m_rate_sum_zz_out,
    output logic                                   m_saturated,

    input  logic                                   cfg_we,
    input  logic [jsr2d_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jsr2d_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import jsr2d_pkg::*;

    // Stage widths: factors, products, full-precision rate numerators
    localparam int U2_W   = GRAD_W + 2;          // 2a - b
    localparam int U1_W   = GRAD_W + 1;          // sums/differences of two fields
    localparam int GS_W   = MOD_W + 1;           // G as a signed operand
    localparam int PA_W   = U2_W + GS_W;         // (2a - b) * G
    localparam int PB_W   = U1_W + GS_W;         // (a + b) * G, d * sxy
    localparam int PC_W   = U1_W + U1_W;         // d * (sxx - syy)
    localparam int X_W    = PA_W + 3;
    localparam int YU_W   = 52;                  // biased, whole 4-bit digits
    localparam int DIG    = YU_W / 4;
    localparam int DIG_HI = 7;
    localparam int DIG_LO = DIG - DIG_HI;
    localparam int R_W    = SUM_W + 2;
    localparam int FAC_STAGES = 6;               // modulus pipeline depth
    localparam int LAST   = FAC_STAGES + 6;      // index of the saturation stage
    localparam logic [YU_W-1:0] DIV3_BIAS = YU_W'(3) << 48;
    localparam logic [R_W-1:0]  DIV3_UNBIAS = R_W'(1) << 48;
    localparam logic signed [R_W-1:0] SUM_MAX = R_W'((64'd1 << (SUM_W-1)) - 64'd1);
    localparam logic signed [R_W-1:0] SUM_MIN = R_W'(64'd0 - (64'd1 << (SUM_W-1)));

    typedef struct packed {
        logic signed [GRAD_W-1:0]   a;
        logic signed [GRAD_W-1:0]   c;
        logic signed [GRAD_W-1:0]   e;
        logic signed [GRAD_W-1:0]   b;
        logic signed [STRESS_W-1:0] sxx;
        logic signed [STRESS_W-1:0] sxy;
        logic signed [STRESS_W-1:0] syy;
        logic        [TEMP_W-1:0]   temp;
    } in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] xx;
        logic signed [SUM_W-1:0] xy;
        logic signed [SUM_W-1:0] yy;
        logic signed [SUM_W-1:0] zz;
    } sums_t;

    typedef struct packed {
        logic signed [U2_W-1:0]     uxx;   // 2a - b
        logic signed [U2_W-1:0]     uyy;   // 2b - a
        logic signed [U1_W-1:0]     d;     // vy_x - vx_y, i.e. 2w
        logic signed [U1_W-1:0]     uxy;   // vx_y + vy_x
        logic signed [U1_W-1:0]     sdif;  // sxx - syy
        logic signed [U1_W-1:0]     tr;    // a + b
        logic signed [STRESS_W-1:0] sxy;
    } fac_t;

    typedef struct packed {
        logic signed [PA_W-1:0] pxx;
        logic signed [PA_W-1:0] pyy;
        logic signed [PB_W-1:0] pw;
        logic signed [PB_W-1:0] pxy;
        logic signed [PC_W-1:0] pd;
        logic signed [PB_W-1:0] ptr;
    } prod_t;

    typedef struct packed {
        logic signed [X_W-1:0] xx;
        logic signed [X_W-1:0] yy;
        logic signed [X_W-1:0] xy;
        logic signed [X_W-1:0] zz;
    } num_t;

    typedef struct packed {
        logic [YU_W-1:0]       yxx;
        logic [YU_W-1:0]       yyy;
        logic [YU_W-1:0]       yzz;
        logic signed [R_W-1:0] rxy;
    } div_in_t;

    typedef struct packed {
        logic [5:0]               rem;
        logic [3*DIG_HI*4-1:0]    qhi;
        logic [3*DIG_LO*4-1:0]    ylo;
        logic signed [R_W-1:0]    rxy;
    } div_mid_t;

    typedef struct packed {
        logic signed [R_W-1:0] rxx;
        logic signed [R_W-1:0] ryy;
        logic signed [R_W-1:0] rxy;
        logic signed [R_W-1:0] rzz;
    } rate_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] xx;
        logic signed [SUM_W-1:0] xy;
        logic signed [SUM_W-1:0] yy;
        logic signed [SUM_W-1:0] zz;
        logic                    sat;
    } res_t;

    // One step of base-16 long division by three; v*43 >> 7 equals v/3 for v < 48.
    function automatic logic [5:0] div3_digit(input logic [1:0] rem, input logic [3:0] dig);
        logic [5:0]  v;
        logic [11:0] p;
        logic [3:0]  q;
        v = {rem, dig};
        p = 12'(v) * 12'd43;
        q = p[10:7];
        return {q, 2'(v - 6'(q) * 6'd3)};
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shear_default <= 31'd180224000;
            cfg_reg.table_en      <= 1'b0;
            cfg_reg.temp_a        <= 16'd4800;
            cfg_reg.temp_b        <= 16'd16000;
            cfg_reg.temp_c        <= 16'd24000;
            cfg_reg.mod_a         <= 31'd180224000;
            cfg_reg.mod_b         <= 31'd180224000;
            cfg_reg.mod_c         <= 31'd180224000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SHEAR_DEFAULT: cfg_reg.shear_default <= cfg_data[MOD_W-1:0];
                CFG_TABLE_ENABLE:  cfg_reg.table_en      <= cfg_data[0];
                CFG_TEMP_KNOT_A:   cfg_reg.temp_a        <= cfg_data[TEMP_W-1:0];
                CFG_TEMP_KNOT_B:   cfg_reg.temp_b        <= cfg_data[TEMP_W-1:0];
                CFG_TEMP_KNOT_C:   cfg_reg.temp_c        <= cfg_data[TEMP_W-1:0];
                CFG_MOD_KNOT_A:    cfg_reg.mod_a         <= cfg_data[MOD_W-1:0];
                CFG_MOD_KNOT_B:    cfg_reg.mod_b         <= cfg_data[MOD_W-1:0];
                CFG_MOD_KNOT_C:    cfg_reg.mod_c         <= cfg_data[MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together unless the skid
    // entry is occupied. Valid bits ride with the data.
    // ------------------------------------------------------------------
    logic             en;
    logic             valid_reg [0:LAST];
    sums_t            sums_reg  [0:LAST-1];
    logic             push;
    res_t             out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign push    = en && valid_reg[LAST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k <= LAST; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Stage 0: capture the transfer
    in_t in_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg.a    <= s_grad_vx_x;
            in_reg.c    <= s_grad_vx_y;
            in_reg.e    <= s_grad_vy_x;
            in_reg.b    <= s_grad_vy_y;
            in_reg.sxx  <= s_stress_xx;
            in_reg.sxy  <= s_stress_xy;
            in_reg.syy  <= s_stress_yy;
            in_reg.temp <= s_temperature;
            sums_reg[0] <= '{xx: s_rate_sum_xx_in, xy: s_rate_sum_xy_in,
                             yy: s_rate_sum_yy_in, zz: s_rate_sum_zz_in};
            for (int k = 1; k < LAST; k++) begin
                sums_reg[k] <= sums_reg[k-1];
            end
        end
    end

    // Stages 1..6: shear modulus lookup; the gradient factors wait alongside
    logic [MOD_W-1:0] g;
    fac_t             fac_next;
    fac_t             fac_reg [1:FAC_STAGES];

    jsr2d_modulus u_modulus (
        .aclk (aclk),
        .en   (en),
        .cfg  (cfg_reg),
        .temp (in_reg.temp),
        .g    (g)
    );

    always_comb begin
        fac_next.uxx  = (U2_W'(in_reg.a) <<< 1) - U2_W'(in_reg.b);
        fac_next.uyy  = (U2_W'(in_reg.b) <<< 1) - U2_W'(in_reg.a);
        fac_next.d    = U1_W'(in_reg.e) - U1_W'(in_reg.c);
        fac_next.uxy  = U1_W'(in_reg.c) + U1_W'(in_reg.e);
        fac_next.sdif = U1_W'(in_reg.sxx) - U1_W'(in_reg.syy);
        fac_next.tr   = U1_W'(in_reg.a) + U1_W'(in_reg.b);
        fac_next.sxy  = in_reg.sxy;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fac_reg[1] <= fac_next;
            for (int k = 2; k <= FAC_STAGES; k++) begin
                fac_reg[k] <= fac_reg[k-1];
            end
        end
    end

    // Stage 7: products
    logic signed [GS_W-1:0] gs;
    prod_t                  prod_next, prod_reg;
    fac_t                   fl;

    always_comb begin
        fl = fac_reg[FAC_STAGES];
        gs = $signed({1'b0, g});
        prod_next.pxx = fl.uxx * gs;
        prod_next.pyy = fl.uyy * gs;
        prod_next.pw  = fl.d * fl.sxy;
        prod_next.pxy = fl.uxy * gs;
        prod_next.pd  = fl.d * fl.sdif;
        prod_next.ptr = fl.tr * gs;
    end

    // Stage 8: numerators, Q36 (Q37 for xy), scaled by three where a third follows
    num_t num_next, num_reg;

    always_comb begin
        num_next.xx = (X_W'(prod_reg.pxx) <<< 1) - X_W'(prod_reg.pw)
                    - (X_W'(prod_reg.pw) <<< 1);
        num_next.yy = (X_W'(prod_reg.pyy) <<< 1) + X_W'(prod_reg.pw)
                    + (X_W'(prod_reg.pw) <<< 1);
        num_next.xy = (X_W'(prod_reg.pxy) <<< 1) + X_W'(prod_reg.pd);
        num_next.zz = X_W'(0) - (X_W'(prod_reg.ptr) <<< 1);
    end

    // Stage 9: floor to Q16, bias non-negative ahead of the divide by three
    div_in_t din_next, din_reg;

    always_comb begin
        din_next.yxx = YU_W'($signed(num_reg.xx[X_W-1:20])) + DIV3_BIAS;
        din_next.yyy = YU_W'($signed(num_reg.yy[X_W-1:20])) + DIV3_BIAS;
        din_next.yzz = YU_W'($signed(num_reg.zz[X_W-1:20])) + DIV3_BIAS;
        din_next.rxy = R_W'($signed(num_reg.xy[X_W-1:21]));
    end

    // Stages 10 and 11: divide the three lanes by three, upper digits then lower
    logic [YU_W-1:0] lane_y [0:2];
    logic [1:0]      lane_r;
    logic [5:0]      step;
    logic [1:0]      lo_r;
    logic [5:0]      lo_step;
    div_mid_t        mid_next, mid_reg;
    rate_t           rate_next, rate_reg;
    logic [YU_W-1:0] lane_q;

    always_comb begin
        lane_y[0] = din_reg.yxx;
        lane_y[1] = din_reg.yyy;
        lane_y[2] = din_reg.yzz;
        mid_next  = '0;
        mid_next.rxy = din_reg.rxy;
        for (int l = 0; l < 3; l++) begin
            lane_r = 2'd0;
            for (int i = 0; i < DIG_HI; i++) begin
                step   = div3_digit(lane_r, lane_y[l][YU_W-1-4*i -: 4]);
                lane_r = step[1:0];
                mid_next.qhi[l*DIG_HI*4 + (DIG_HI-1-i)*4 +: 4] = step[5:2];
            end
            mid_next.rem[l*2 +: 2] = lane_r;
            mid_next.ylo[l*DIG_LO*4 +: DIG_LO*4] = lane_y[l][DIG_LO*4-1:0];
        end
    end

    always_comb begin
        rate_next     = '0;
        rate_next.rxy = mid_reg.rxy;
        lane_q        = '0;
        for (int l = 0; l < 3; l++) begin
            lo_r = mid_reg.rem[l*2 +: 2];
            lane_q[YU_W-1 -: DIG_HI*4] = mid_reg.qhi[l*DIG_HI*4 +: DIG_HI*4];
            for (int i = 0; i < DIG_LO; i++) begin
                lo_step = div3_digit(lo_r,
                                     mid_reg.ylo[l*DIG_LO*4 + (DIG_LO-1-i)*4 +: 4]);
                lo_r    = lo_step[1:0];
                lane_q[(DIG_LO-1-i)*4 +: 4] = lo_step[5:2];
            end
            // drop the bias: 3 * 2^48 / 3
            case (l)
                0:       rate_next.rxx = $signed(lane_q[R_W-1:0] - DIV3_UNBIAS);
                1:       rate_next.ryy = $signed(lane_q[R_W-1:0] - DIV3_UNBIAS);
                default: rate_next.rzz = $signed(lane_q[R_W-1:0] - DIV3_UNBIAS);
            endcase
        end
    end

    // Stage 12: add to the running sums and saturate
    res_t                  res_next, res_reg;
    logic signed [R_W-1:0] sxx_w, sxy_w, syy_w, szz_w;
    sums_t                 sl;

    always_comb begin
        sl    = sums_reg[LAST-1];
        sxx_w = R_W'(sl.xx) + rate_reg.rxx;
        sxy_w = R_W'(sl.xy) + rate_reg.rxy;
        syy_w = R_W'(sl.yy) + rate_reg.ryy;
        szz_w = R_W'(sl.zz) + rate_reg.rzz;
        res_next.sat = (sxx_w > SUM_MAX) || (sxx_w < SUM_MIN)
                    || (sxy_w > SUM_MAX) || (sxy_w < SUM_MIN)
                    || (syy_w > SUM_MAX) || (syy_w < SUM_MIN)
                    || (szz_w > SUM_MAX) || (szz_w < SUM_MIN);
        res_next.xx = (sxx_w > SUM_MAX) ? SUM_MAX[SUM_W-1:0] :
                      (sxx_w < SUM_MIN) ? SUM_MIN[SUM_W-1:0] : sxx_w[SUM_W-1:0];
        res_next.xy = (sxy_w > SUM_MAX) ? SUM_MAX[SUM_W-1:0] :
                      (sxy_w < SUM_MIN) ? SUM_MIN[SUM_W-1:0] : sxy_w[SUM_W-1:0];
        res_next.yy = (syy_w > SUM_MAX) ? SUM_MAX[SUM_W-1:0] :
                      (syy_w < SUM_MIN) ? SUM_MIN[SUM_W-1:0] : syy_w[SUM_W-1:0];
        res_next.zz = (szz_w > SUM_MAX) ? SUM_MAX[SUM_W-1:0] :
                      (szz_w < SUM_MIN) ? SUM_MIN[SUM_W-1:0] : szz_w[SUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            num_reg  <= num_next;
            din_reg  <= din_next;
            mid_reg  <= mid_next;
            rate_reg <= rate_next;
            res_reg  <= res_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry. A result that leaves the last
    // stage while the output register is held parks in the skid entry,
    // which in turn holds the whole pipeline until it drains.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : res_reg;
        end else if (push) begin
            skid_reg <= res_reg;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_rate_sum_xx_out = out_reg.xx;
    assign m_rate_sum_xy_out = out_reg.xy;
    assign m_rate_sum_yy_out = out_reg.yy;
    assign m_rate_sum_zz_out = out_reg.zz;
    assign m_saturated       = out_reg.sat;

endmodule

// ----- src/jsr2d_modulus.sv -----
module jsr2d_modulus (
    input  logic                          aclk,
    input  logic                          en,
    input  jsr2d_pkg::cfg_t               cfg,
    input  logic [jsr2d_pkg::TEMP_W-1:0]  temp,
    output logic [jsr2d_pkg::MOD_W-1:0]   g
);
    import jsr2d_pkg::*;

    localparam int DIV_STAGES = 4;
    localparam int STEPS      = 8;
    localparam int QW         = DIV_STAGES * STEPS;
    localparam int DW         = TEMP_W;
    localparam int NW         = QW + DW;
    localparam int GW         = MOD_W + 3;

    typedef enum logic [1:0] {
        GSEL_DEFAULT,
        GSEL_FIXED,
        GSEL_INTERP
    } gsel_t;

    typedef struct packed {
        gsel_t            sel;
        logic [MOD_W-1:0] m0;
        logic             neg;
        logic [DW-1:0]    den;
        logic [DW-1:0]    rem;
        logic [QW-1:0]    nlo;
        logic [QW-1:0]    q;
    } div_t;

    div_t             st_reg   [0:DIV_STAGES];
    div_t             div_next [1:DIV_STAGES];
    div_t             sel_next;
    logic [MOD_W-1:0] g_reg;
    logic [MOD_W-1:0] g_next;

    logic [TEMP_W-1:0] t0, t1, dt;
    logic [MOD_W-1:0]  m0, m1;
    logic [MOD_W:0]    dm, mag;
    logic [NW-1:0]     num;
    logic [DW:0]       trial;
    logic [GW-1:0]     qx, qr, gi;
    div_t              fin;

    // Segment select and numerator product
    always_comb begin
        sel_next = '0;
        if (temp < cfg.temp_b) begin
            t0 = cfg.temp_a;
            t1 = cfg.temp_b;
            m0 = cfg.mod_a;
            m1 = cfg.mod_b;
        end else begin
            t0 = cfg.temp_b;
            t1 = cfg.temp_c;
            m0 = cfg.mod_b;
            m1 = cfg.mod_c;
        end
        dm  = {1'b0, m1} - {1'b0, m0};
        mag = dm[MOD_W] ? ((MOD_W+1)'(0) - dm) : dm;
        dt  = temp - t0;
        num = NW'(mag[MOD_W-1:0]) * NW'(dt);

        sel_next.m0  = m0;
        sel_next.neg = dm[MOD_W];
        sel_next.den = t1 - t0;
        sel_next.rem = num[NW-1:QW];
        sel_next.nlo = num[QW-1:0];
        if (!cfg.table_en) begin
            sel_next.sel = GSEL_DEFAULT;
        end else if (temp <= cfg.temp_a) begin
            sel_next.sel = GSEL_FIXED;
            sel_next.m0  = cfg.mod_a;
        end else if (temp >= cfg.temp_c) begin
            sel_next.sel = GSEL_FIXED;
            sel_next.m0  = cfg.mod_c;
        end else if (t1 <= t0) begin
            sel_next.sel = GSEL_DEFAULT;
        end else begin
            sel_next.sel = GSEL_INTERP;
        end
    end

    // Restoring division, STEPS quotient bits per stage
    always_comb begin
        trial = '0;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            div_next[k] = st_reg[k-1];
            for (int s = 0; s < STEPS; s++) begin
                trial = {div_next[k].rem, div_next[k].nlo[QW-1]};
                div_next[k].nlo = {div_next[k].nlo[QW-2:0], 1'b0};
                if (trial >= {1'b0, div_next[k].den}) begin
                    div_next[k].rem = DW'(trial - {1'b0, div_next[k].den});
                    div_next[k].q   = {div_next[k].q[QW-2:0], 1'b1};
                end else begin
                    div_next[k].rem = trial[DW-1:0];
                    div_next[k].q   = {div_next[k].q[QW-2:0], 1'b0};
                end
            end
        end
    end

    // Floor the signed quotient, add the base knot, fall back to the default
    always_comb begin
        fin = st_reg[DIV_STAGES];
        qx  = GW'(fin.q);
        qr  = (fin.rem != '0) ? (qx + GW'(1)) : qx;
        gi  = GW'(fin.m0) + (fin.neg ? (GW'(0) - qr) : qx);
        case (fin.sel)
            GSEL_FIXED: begin
                g_next = (fin.m0 == '0) ? cfg.shear_default : fin.m0;
            end
            GSEL_INTERP: begin
                g_next = (gi[GW-1] || gi == '0) ? cfg.shear_default : gi[MOD_W-1:0];
            end
            default: begin
                g_next = cfg.shear_default;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= sel_next;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                st_reg[k] <= div_next[k];
            end
            g_reg <= g_next;
        end
    end

    assign g = g_reg;

endmodule

// ----- test/jsr2d_checker.sv -----
`timescale 1ns / 1ps

module jsr2d_checker
    import jsr2d_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [GRAD_W-1:0]    s_grad_vx_x,
    input  logic signed [GRAD_W-1:0]    s_grad_vx_y,
    input  logic signed [GRAD_W-1:0]    s_grad_vy_x,
    input  logic signed [GRAD_W-1:0]    s_grad_vy_y,
    input  logic signed [STRESS_W-1:0]  s_stress_xx,
    input  logic signed [STRESS_W-1:0]  s_stress_xy,
    input  logic signed [STRESS_W-1:0]  s_stress_yy,
    input  logic        [TEMP_W-1:0]    s_temperature,
    input  logic signed [SUM_W-1:0]     s_rate_sum_xx_in,
    input  logic signed [SUM_W-1:0]     s_rate_sum_xy_in,
    input  logic signed [SUM_W-1:0]     s_rate_sum_yy_in,
    input  logic signed [SUM_W-1:0]     s_rate_sum_zz_in,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [SUM_W-1:0]     m_rate_sum_xx_out,
    input  logic signed [SUM_W-1:0]     m_rate_sum_xy_out,
    input  logic signed [SUM_W-1:0]     m_rate_sum_yy_out,
    input  logic signed [SUM_W-1:0]     m_rate_sum_zz_out,
    input  logic                        m_saturated,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output int                          fail_count,
    output int                          pending_sums,
    output int                          checked_count,
    output int                          sat_count
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [SUM_W-1:0] xx;
        logic signed [SUM_W-1:0] xy;
        logic signed [SUM_W-1:0] yy;
        logic signed [SUM_W-1:0] zz;
        logic                    sat;
    } sums_t;

    cfg_t  regs;
    sums_t expected_sums[$];

    function automatic wide_t floor_div(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (q * d != n && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic wide_t shear_modulus(logic [TEMP_W-1:0] t);
        wide_t g, t0, t1, m0, m1, tt;
        tt = wide_t'({1'b0, t});
        if (!regs.table_en)
            return wide_t'({1'b0, regs.shear_default});
        if (t <= regs.temp_a) begin
            g = wide_t'({1'b0, regs.mod_a});
        end else if (t >= regs.temp_c) begin
            g = wide_t'({1'b0, regs.mod_c});
        end else begin
            if (t < regs.temp_b) begin
                t0 = {1'b0, regs.temp_a}; t1 = {1'b0, regs.temp_b};
                m0 = {1'b0, regs.mod_a};  m1 = {1'b0, regs.mod_b};
            end else begin
                t0 = {1'b0, regs.temp_b}; t1 = {1'b0, regs.temp_c};
                m0 = {1'b0, regs.mod_b};  m1 = {1'b0, regs.mod_c};
            end
            // degenerate segment falls back to the default
            if (t1 - t0 <= 0)
                return wide_t'({1'b0, regs.shear_default});
            g = m0 + floor_div((m1 - m0) * (tt - t0), t1 - t0);
        end
        if (g <= 0)
            g = wide_t'({1'b0, regs.shear_default});
        return g;
    endfunction

    function automatic logic signed [SUM_W-1:0] clamp_add(logic signed [SUM_W-1:0] base,
                                                         wide_t rate, ref logic flag);
        wide_t s, hi, lo;
        hi = (wide_t'(1) <<< (SUM_W - 1)) - 1;
        lo = -hi - 1;
        s = wide_t'(base) + rate;
        if (s > hi) begin s = hi; flag = 1'b1; end
        if (s < lo) begin s = lo; flag = 1'b1; end
        return s[SUM_W-1:0];
    endfunction

    function automatic sums_t predict_sums();
        wide_t a, b, c, e, sxx, sxy, syy, g, d, q20, q21;
        sums_t r;
        logic flag;
        a = s_grad_vx_x; c = s_grad_vx_y; e = s_grad_vy_x; b = s_grad_vy_y;
        sxx = s_stress_xx; sxy = s_stress_xy; syy = s_stress_yy;
        g = shear_modulus(s_temperature);
        d = e - c;
        q20 = wide_t'(3) <<< 20;
        q21 = wide_t'(1) <<< 21;
        flag = 1'b0;
        // one floor rounding per component, division by three folded in
        r.xx = clamp_add(s_rate_sum_xx_in,
                         floor_div(2 * (2 * a - b) * g - 3 * d * sxy, q20), flag);
        r.xy = clamp_add(s_rate_sum_xy_in,
                         floor_div((c + e) * 2 * g + d * (sxx - syy), q21), flag);
        r.yy = clamp_add(s_rate_sum_yy_in,
                         floor_div(2 * (2 * b - a) * g + 3 * d * sxy, q20), flag);
        r.zz = clamp_add(s_rate_sum_zz_in, floor_div(-2 * (a + b) * g, q20), flag);
        r.sat = flag;
        return r;
    endfunction

    task automatic compare_field(string name, logic signed [SUM_W-1:0] exp_v,
                                 logic signed [SUM_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending_sums = 0;
        checked_count = 0;
        sat_count = 0;
        regs = '{shear_default: 31'd180224000, table_en: 1'b0, temp_a: 16'd4800,
                 temp_b: 16'd16000, temp_c: 16'd24000, mod_a: 31'd180224000,
                 mod_b: 31'd180224000, mod_c: 31'd180224000};
    end

    always @(posedge aclk) begin
        sums_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_sums = {expected_sums, predict_sums()};
            if (m_valid && m_ready) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected result transfer");
                    fail_count++;
                end else begin
                    want = expected_sums.pop_front();
                    compare_field("rate_sum_xx_out", want.xx, m_rate_sum_xx_out);
                    compare_field("rate_sum_xy_out", want.xy, m_rate_sum_xy_out);
                    compare_field("rate_sum_yy_out", want.yy, m_rate_sum_yy_out);
                    compare_field("rate_sum_zz_out", want.zz, m_rate_sum_zz_out);
                    if (want.sat !== m_saturated) begin
                        $error("saturated mismatch: expected %0d, actual %0d",
                               want.sat, m_saturated);
                        fail_count++;
                    end
                    checked_count++;
                    if (want.sat)
                        sat_count++;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SHEAR_DEFAULT: regs.shear_default = cfg_data[MOD_W-1:0];
                    CFG_TABLE_ENABLE:  regs.table_en      = cfg_data[0];
                    CFG_TEMP_KNOT_A:   regs.temp_a        = cfg_data[TEMP_W-1:0];
                    CFG_TEMP_KNOT_B:   regs.temp_b        = cfg_data[TEMP_W-1:0];
                    CFG_TEMP_KNOT_C:   regs.temp_c        = cfg_data[TEMP_W-1:0];
                    CFG_MOD_KNOT_A:    regs.mod_a         = cfg_data[MOD_W-1:0];
                    CFG_MOD_KNOT_B:    regs.mod_b         = cfg_data[MOD_W-1:0];
                    CFG_MOD_KNOT_C:    regs.mod_c         = cfg_data[MOD_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_sums = expected_sums.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import jsr2d_pkg::*;

    localparam int  DRAIN_CYCLES = 40;       // comfortably past the pipeline latency
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int  PROBE_COUNT = 9;
    localparam logic [TEMP_W-1:0] PROBE_TEMPS [0:PROBE_COUNT-1] =
        '{16'd0, 16'd4800, 16'd4801, 16'd15999, 16'd16000, 16'd20000,
          16'd23999, 16'd24000, 16'hFFFF};

    typedef struct {
        logic [GRAD_W-1:0]   vx_x, vx_y, vy_x, vy_y;
        logic [STRESS_W-1:0] sxx, sxy, syy;
        logic [TEMP_W-1:0]   temp;
        logic [SUM_W-1:0]    sum_xx, sum_xy, sum_yy, sum_zz;
    } particle_t;

    logic aclk;
    logic aresetn;
    logic s_valid, s_ready;
    logic signed [GRAD_W-1:0]   s_grad_vx_x, s_grad_vx_y, s_grad_vy_x, s_grad_vy_y;
    logic signed [STRESS_W-1:0] s_stress_xx, s_stress_xy, s_stress_yy;
    logic        [TEMP_W-1:0]   s_temperature;
    logic signed [SUM_W-1:0]    s_rate_sum_xx_in, s_rate_sum_xy_in;
    logic signed [SUM_W-1:0]    s_rate_sum_yy_in, s_rate_sum_zz_in;
    logic m_valid, m_ready;
    logic signed [SUM_W-1:0]    m_rate_sum_xx_out, m_rate_sum_xy_out;
    logic signed [SUM_W-1:0]    m_rate_sum_yy_out, m_rate_sum_zz_out;
    logic m_saturated;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count, pending_sums, checked_count, sat_count;
    int sender_idle_pct, receiver_stall_pct;
    longint cycle_count;

    jaumann_stress_rate_2d_unit dut (.*);

    jsr2d_checker u_checker (.*);

    // Clock: 10 ns period
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: abort a hung run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: stall on m_ready at the rate of the current phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Gradient mix: full range, moderate and tiny values so that not every sum clamps
    function automatic logic [GRAD_W-1:0] pick_grad();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return GRAD_W'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            2: return GRAD_W'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
            default: return '0;
        endcase
    endfunction

    function automatic logic [STRESS_W-1:0] pick_stress();
        if ($urandom_range(0, 1))
            return $urandom;
        return STRESS_W'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endfunction

    // Sums: mostly anywhere, sometimes hugging either rail to force clamping
    function automatic logic [SUM_W-1:0] pick_sum();
        logic [SUM_W-1:0] v;
        v = SUM_W'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: v = {1'b0, {(SUM_W-1){1'b1}}} - SUM_W'($urandom_range(0, 1 << 20));
            1: v = {1'b1, {(SUM_W-1){1'b0}}} + SUM_W'($urandom_range(0, 1 << 20));
            2: v = SUM_W'($signed($urandom_range(0, 1 << 30)) - (1 << 29));
            default: ;
        endcase
        return v;
    endfunction

    // Temperature: full range or near a knot of the reset table
    function automatic logic [TEMP_W-1:0] pick_temp();
        case ($urandom_range(0, 3))
            0: return 16'd4800 + TEMP_W'($urandom_range(0, 4)) - 16'd2;
            1: return 16'd16000 + TEMP_W'($urandom_range(0, 4)) - 16'd2;
            2: return 16'd24000 + TEMP_W'($urandom_range(0, 4)) - 16'd2;
            default: return TEMP_W'($urandom);
        endcase
    endfunction

    function automatic particle_t random_particle();
        particle_t p;
        p.vx_x = pick_grad(); p.vx_y = pick_grad();
        p.vy_x = pick_grad(); p.vy_y = pick_grad();
        p.sxx = pick_stress(); p.sxy = pick_stress(); p.syy = pick_stress();
        p.temp = pick_temp();
        p.sum_xx = pick_sum(); p.sum_xy = pick_sum();
        p.sum_yy = pick_sum(); p.sum_zz = pick_sum();
        return p;
    endfunction

    // Fill every field with one pattern, then set the temperature
    function automatic particle_t uniform_particle(logic [SUM_W-1:0] pat,
                                                   logic [TEMP_W-1:0] t);
        particle_t p;
        p.vx_x = pat[GRAD_W-1:0]; p.vx_y = pat[GRAD_W-1:0];
        p.vy_x = pat[GRAD_W-1:0]; p.vy_y = pat[GRAD_W-1:0];
        p.sxx = pat[STRESS_W-1:0]; p.sxy = pat[STRESS_W-1:0]; p.syy = pat[STRESS_W-1:0];
        p.temp = t;
        p.sum_xx = pat; p.sum_xy = pat; p.sum_yy = pat; p.sum_zz = pat;
        return p;
    endfunction

    // Drive one particle and hold it until the transfer; called at a falling edge
    task automatic send_particle(particle_t p);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_grad_vx_x <= p.vx_x; s_grad_vx_y <= p.vx_y;
        s_grad_vy_x <= p.vy_x; s_grad_vy_y <= p.vy_y;
        s_stress_xx <= p.sxx; s_stress_xy <= p.sxy; s_stress_yy <= p.syy;
        s_temperature <= p.temp;
        s_rate_sum_xx_in <= p.sum_xx; s_rate_sum_xy_in <= p.sum_xy;
        s_rate_sum_yy_in <= p.sum_yy; s_rate_sum_zz_in <= p.sum_zz;
        s_valid <= 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        @(negedge aclk);
    endtask

    // Drop valid and let the pipeline empty before touching registers
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_sums != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Present one write to the register port; the caller drops the enable after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
    endtask

    task automatic load_table(logic en, logic [15:0] ta, logic [15:0] tb_k,
                              logic [15:0] tc, logic [30:0] ma, logic [30:0] mb,
                              logic [30:0] mc, logic [30:0] dflt);
        drain_pipeline();
        write_reg(CFG_SHEAR_DEFAULT, dflt);
        write_reg(CFG_TABLE_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_TEMP_KNOT_A, CFG_DATA_W'(ta));
        write_reg(CFG_TEMP_KNOT_B, CFG_DATA_W'(tb_k));
        write_reg(CFG_TEMP_KNOT_C, CFG_DATA_W'(tc));
        write_reg(CFG_MOD_KNOT_A, ma);
        write_reg(CFG_MOD_KNOT_B, mb);
        write_reg(CFG_MOD_KNOT_C, mc);
        cfg_we <= 1'b0;
    endtask

    // Random particles under one idling mix; optionally hold off mid-phase
    task automatic random_phase(int count, int idle_pct, int stall_pct, bit hold_off);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            if (hold_off && i == count / 2) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending_sums != 0)
                    @(negedge aclk);
            end
            send_particle(random_particle());
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        {s_grad_vx_x, s_grad_vx_y, s_grad_vy_x, s_grad_vy_y} = '0;
        {s_stress_xx, s_stress_xy, s_stress_yy, s_temperature} = '0;
        {s_rate_sum_xx_in, s_rate_sum_xy_in, s_rate_sum_yy_in, s_rate_sum_zz_in} = '0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed corners under reset registers: zero, rails, alternating bits
        send_particle(uniform_particle('0, '0));
        send_particle(uniform_particle('1, '1));
        send_particle(uniform_particle(48'h7FFF_7FFF_FFFF, 16'h7FFF));
        send_particle(uniform_particle(48'h8000_8000_0000, 16'h8000));
        send_particle(uniform_particle(48'h5555_5555_5555, 16'h5555));
        send_particle(uniform_particle(48'hAAAA_AAAA_AAAA, 16'hAAAA));

        // Table on with default knots: below, at and between knots, and past the top
        load_table(1'b1, 16'd4800, 16'd16000, 16'd24000,
                   31'd100000000, 31'd180224000, 31'd60000000, 31'd180224000);
        for (int k = 0; k < PROBE_COUNT; k++) begin
            particle_t p;
            p = random_particle();
            p.temp = PROBE_TEMPS[k];
            send_particle(p);
        end
        // Rails of the sums with a nonzero rate, to reach both clamps
        send_particle(uniform_particle(48'h7FFF_7FFF_FFFF, 16'd20000));
        send_particle(uniform_particle(48'h8000_8000_0000, 16'd20000));

        random_phase(350, 0, 0, 1'b0);
        random_phase(350, 58, 0, 1'b1);

        // Knots out of order and a modulus of zero: exercise the fallbacks
        load_table(1'b1, 16'd20000, 16'd8000, 16'd24000,
                   31'd0, 31'h7FFFFFFF, 31'd0, 31'd12345678);
        random_phase(350, 0, 58, 1'b0);

        // Extremes: widest table, largest moduli, then zero and top defaults, table off
        load_table(1'b1, 16'd0, 16'd32768, 16'hFFFF,
                   31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF, 31'h7FFFFFFF);
        random_phase(350, 9, 9, 1'b0);
        load_table(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   31'd0, 31'd0, 31'd0, 31'd0);
        random_phase(200, 58, 58, 1'b0);
        load_table(1'b0, 16'd4800, 16'd16000, 16'd24000,
                   31'd180224000, 31'd180224000, 31'd180224000, 31'h7FFFFFFF);
        random_phase(200, 0, 0, 1'b0);

        drain_pipeline();
        $display("Covered %0d particles across six register settings and five idling mixes,",
                 checked_count);
        $display("%0d of them with at least one clamped sum.", sat_count);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
